/* sv/dna_string_set_insert_find_top_defines.svh */
// assertion macros for the asserting top module
`ifndef DNA_STRING_SET_INSERT_FIND_TOP_DEFINES_SVH
`define DNA_STRING_SET_INSERT_FIND_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DSSIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define DSSIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dssif_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dssif_pkg;

  localparam int KEY_W     = 28;
  localparam int CNT_W     = 4;

  localparam logic [CNT_W-1:0] MAX_LEN = 4'd12;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_KEY = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_T = 8'h54;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_ACC,
    ST_EVAL,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  function automatic logic [2:0] digit_of(input logic [7:0] ch);
    logic [2:0] d;
    case (ch)
      CH_A:    d = 3'd1;
      CH_C:    d = 3'd2;
      CH_G:    d = 3'd3;
      CH_T:    d = 3'd4;
      default: d = 3'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* sv/dna_string_set_insert_find_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  beat contents
// s_axis    in   tdata = symbol_char, tuser = op (0 insert, 1 find), tlast = end of string
// m_axis    out  tdata = found, inserted, status; one beat per string
//
// sequence: characters are taken while accumulating; after the last character come
//   evaluate, three-step reciprocal key mod depth and hand-off, then a read and
//   a compare per probed slot through the single-port key table, then a result load
// reset: a clearing pass writes every table slot with s_tready low
// stalls: characters are taken while a previous result waits on m_axis;
//   a finished lookup holds in the done state until the result register frees
module dna_string_set_insert_find_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] symbol_char
  input  wire logic       s_tuser,   // [0] op
  input  wire logic       s_tlast,   // last character of the string
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata    // [0] found, [1] inserted, [3:2] status, [7:4] zero
);
  import dssif_pkg::*;

  localparam int ABITS = $clog2(TABLE_DEPTH);
  localparam logic [ABITS-1:0] LAST_SLOT = ABITS'(TABLE_DEPTH - 1);

  state_t state, state_next;

  // per-string accumulation
  logic [KEY_W-1:0] key_acc, key_acc_next;
  logic [KEY_W-1:0] weight, weight_next;
  logic [CNT_W-1:0] char_cnt, char_cnt_next;
  logic             ovf, ovf_next;
  logic [KEY_W-1:0] term;
  logic             beat;

  // lookup of the finished string
  logic [KEY_W-1:0] probe_key;
  logic             probe_ovf;
  logic             probe_op;
  logic [ABITS-1:0] slot;
  logic [ABITS-1:0] probe_cnt;
  logic             probe_last;
  logic [ABITS-1:0] clr_addr;

  logic       res_found;
  logic       res_inserted;
  logic [1:0] res_status;

  // table port
  logic             ram_we;
  logic [ABITS-1:0] ram_addr;
  logic [KEY_W:0]   ram_wdata;
  logic [KEY_W:0]   ram_rdata;
  logic             rd_valid;
  logic             rd_match;

  logic             mod_start;
  logic             mod_done;
  logic [ABITS-1:0] mod_rem;
  logic             out_load;

  assign beat       = s_tvalid && s_tready;
  assign rd_valid   = ram_rdata[KEY_W];
  assign rd_match   = rd_valid && (ram_rdata[KEY_W-1:0] == probe_key);
  assign probe_last = (probe_cnt == LAST_SLOT);

  // digit times weight by shifts and an add, then weight times five
  always_comb begin
    case (digit_of(s_tdata))
      3'd1:    term = weight;
      3'd2:    term = {weight[KEY_W-2:0], 1'b0};
      3'd3:    term = {weight[KEY_W-2:0], 1'b0} + weight;
      3'd4:    term = {weight[KEY_W-3:0], 2'b00};
      default: term = '0;
    endcase
  end

  always_comb begin
    key_acc_next  = key_acc;
    weight_next   = weight;
    char_cnt_next = char_cnt;
    ovf_next      = ovf;
    if (char_cnt >= MAX_LEN) begin
      ovf_next = 1'b1;
    end else begin
      key_acc_next  = key_acc + term;
      weight_next   = {weight[KEY_W-3:0], 2'b00} + weight;
      char_cnt_next = char_cnt + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_SLOT) state_next = ST_ACC;
      end
      ST_ACC: begin
        if (beat && s_tlast) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (probe_ovf || (probe_key == '0)) state_next = ST_DONE;
        else state_next = ST_HASH;
      end
      ST_HASH: begin
        if (mod_done) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (!rd_valid || rd_match || probe_last) state_next = ST_DONE;
        else state_next = ST_READ;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_ACC;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    mod_start = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = slot;
    ram_wdata = {1'b1, probe_key};
    out_load  = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_ACC: begin
        s_tready = 1'b1;
      end
      ST_EVAL: begin
        mod_start = !probe_ovf && (probe_key != '0);
      end
      ST_CMP: begin
        // first free slot on an insert takes the key
        ram_we = !rd_valid && (probe_op == OP_INSERT);
      end
      ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      key_acc  <= '0;
      weight   <= KEY_W'(1);
      char_cnt <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (beat) begin
        if (s_tlast) begin
          key_acc  <= '0;
          weight   <= KEY_W'(1);
          char_cnt <= '0;
          ovf      <= 1'b0;
        end else begin
          key_acc  <= key_acc_next;
          weight   <= weight_next;
          char_cnt <= char_cnt_next;
          ovf      <= ovf_next;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // lookup datapath
  always_ff @(posedge clk) begin
    if (beat && s_tlast) begin
      probe_key <= key_acc_next;
      probe_ovf <= ovf_next;
      probe_op  <= s_tuser;
    end
    case (state)
      ST_EVAL: begin
        res_found    <= 1'b0;
        res_inserted <= 1'b0;
        if (probe_ovf) res_status <= STATUS_TOO_LONG;
        else if (probe_key == '0) res_status <= STATUS_ZERO_KEY;
        else res_status <= STATUS_OK;
      end
      ST_HASH: begin
        slot      <= mod_rem;
        probe_cnt <= '0;
      end
      ST_CMP: begin
        if (!rd_valid) begin
          res_inserted <= (probe_op == OP_INSERT);
        end else if (rd_match) begin
          res_found <= 1'b1;
        end else if (probe_last) begin
          // every slot visited without a match
          res_status <= (probe_op == OP_INSERT) ? STATUS_FULL : STATUS_OK;
        end else begin
          probe_cnt <= probe_cnt + 1'b1;
          slot      <= (slot == LAST_SLOT) ? '0 : slot + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_tdata <= {4'b0000, res_status, res_inserted, res_found};
    end
  end

  dssif_mod #(
    .DEPTH(TABLE_DEPTH)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (probe_key),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  // key table: valid bit on top of the key
  dssif_ram #(
    .WIDTH(KEY_W + 1),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

`include "dna_string_set_insert_find_top_defines.svh"

  `DSSIF_ASSERT_NEXT(a_last_starts_eval, beat && s_tlast, state == ST_EVAL, "no eval after last")
  `DSSIF_ASSERT_NOW(a_count_bound, 1'b1, char_cnt <= MAX_LEN, "char count past limit")
  `DSSIF_ASSERT_NOW(a_write_free, ram_we, (state == ST_CLEAR) || (state == ST_CMP && !rd_valid), "stray write")
  `DSSIF_ASSERT_NOW(a_insert_clean, m_tvalid && m_tdata[1], !m_tdata[0] && (m_tdata[3:2] == STATUS_OK), "bad insert")

endmodule
`default_nettype wire

/* sv/dssif_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module dssif_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* sv/dssif_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// remainder of a key by the table depth through a reciprocal multiply, three steps
module dssif_mod #(
  parameter int DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [dssif_pkg::KEY_W-1:0]      dividend,
  output logic                                  done,
  output logic      [$clog2(DEPTH)-1:0]         remainder
);
  import dssif_pkg::*;

  localparam int ABITS = $clog2(DEPTH);
  // floor of 2^KEY_W over the depth; the quotient estimate is short by at most one
  localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / DEPTH);
  localparam logic [KEY_W-1:0] DIV_K   = KEY_W'(DEPTH);
  localparam logic [ABITS:0]   DIVISOR = (ABITS+1)'(DEPTH);

  logic [1:0]         step;
  logic [KEY_W-1:0]   dvd;
  logic [KEY_W-1:0]   quot;
  logic [KEY_W-1:0]   back;
  logic [KEY_W-1:0]   diff;
  logic [2*KEY_W-1:0] prod;
  logic [ABITS:0]     rem_est;
  logic [ABITS:0]     rem_sub;

  assign prod    = {{KEY_W{1'b0}}, dvd} * {{KEY_W{1'b0}}, RECIP};
  assign back    = quot * DIV_K;
  // below twice the divisor, so ABITS+1 bits hold it
  assign diff    = dvd - back;
  assign rem_sub = rem_est - DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= (step == 2'd3);
      if (start) begin
        step <= 2'd1;
      end else if (step != 2'd0) begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (step == 2'd1) begin
      quot <= prod[2*KEY_W-1:KEY_W];
    end
    if (step == 2'd2) begin
      rem_est <= diff[ABITS:0];
    end
    if (step == 2'd3) begin
      if (rem_est >= DIVISOR) begin
        remainder <= rem_sub[ABITS-1:0];
      end else begin
        remainder <= rem_est[ABITS-1:0];
      end
    end
  end

endmodule
`default_nettype wire
